// ===== rtl/dgcb_pkg.sv =====
package dgcb_pkg;

  // Default grid side limit handed to the top level parameter.
  localparam int MAX_ROW_CELLS_DEF = 1024;

  // Fixed field widths of the request and result channels.
  localparam int POS_W    = 32;
  localparam int CELL_W   = 10;
  localparam int INDEX_W  = 20;
  localparam int COUNT_W  = 32;
  localparam int RADIUS_W = 31;
  localparam int ROWS_W   = 11;

  // Configuration port geometry.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Probe geometry: nine probe points built from five offsets per axis.
  localparam int NUM_PROBES = 9;
  localparam int NUM_COORDS = 5;

  // cos(45 degrees) in Q16.16, rounded to nearest.
  localparam logic [15:0] COS45_Q16 = 16'd46341;

  // Register reset values.
  localparam logic [31:0] RANGE_LOW_RST  = 32'd0;
  localparam logic [31:0] CELL_SCALE_RST = 32'd65536;
  localparam logic [30:0] RADIUS_RST     = 31'd0;
  localparam logic [10:0] ROWS_RST       = 11'd64;

  // Register map, one word per register.
  typedef enum logic [1:0] {
    REG_RANGE_LOW   = 2'd0,
    REG_CELL_SCALE  = 2'd1,
    REG_DISC_RADIUS = 2'd2,
    REG_ROW_CELLS   = 2'd3
  } reg_index_t;

  // Per-axis coordinate slots.
  localparam logic [2:0] COORD_CENTER    = 3'd0;
  localparam logic [2:0] COORD_PLUS_RAD  = 3'd1;
  localparam logic [2:0] COORD_MINUS_RAD = 3'd2;
  localparam logic [2:0] COORD_PLUS_OFF  = 3'd3;
  localparam logic [2:0] COORD_MINUS_OFF = 3'd4;

  // Load enables of the five pipeline stages in front of the emit buffer.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } pipe_en_t;

  // Which x coordinate slot a probe uses.
  function automatic logic [2:0] probe_x_sel(input logic [3:0] probe);
    logic [2:0] sel;
    case (probe)
      4'd0: sel = COORD_CENTER;
      4'd1: sel = COORD_PLUS_RAD;
      4'd2: sel = COORD_MINUS_RAD;
      4'd3: sel = COORD_CENTER;
      4'd4: sel = COORD_CENTER;
      4'd5: sel = COORD_PLUS_OFF;
      4'd6: sel = COORD_MINUS_OFF;
      4'd7: sel = COORD_PLUS_OFF;
      4'd8: sel = COORD_MINUS_OFF;
      default: sel = COORD_CENTER;
    endcase
    return sel;
  endfunction

  // Which y coordinate slot a probe uses.
  function automatic logic [2:0] probe_y_sel(input logic [3:0] probe);
    logic [2:0] sel;
    case (probe)
      4'd0: sel = COORD_CENTER;
      4'd1: sel = COORD_CENTER;
      4'd2: sel = COORD_CENTER;
      4'd3: sel = COORD_PLUS_RAD;
      4'd4: sel = COORD_MINUS_RAD;
      4'd5: sel = COORD_PLUS_OFF;
      4'd6: sel = COORD_PLUS_OFF;
      4'd7: sel = COORD_MINUS_OFF;
      4'd8: sel = COORD_MINUS_OFF;
      default: sel = COORD_CENTER;
    endcase
    return sel;
  endfunction

endpackage

// ===== rtl/dgcb_cfg.sv =====
module dgcb_cfg
  import dgcb_pkg::*;
#(
  parameter int MAX_ROW_CELLS = MAX_ROW_CELLS_DEF,
  parameter int CW            = $clog2(MAX_ROW_CELLS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output logic [POS_W-1:0]    range_low,
  output logic [31:0]         cell_scale,
  output logic [RADIUS_W-1:0] disc_radius,
  output logic [RADIUS_W-1:0] diag_offset,
  output logic [CW-1:0]       grid_cells
);

  logic [ROWS_W-1:0] row_cells;
  logic              wr_en;
  reg_index_t        reg_sel;
  logic [46:0]       diag_prod;
  logic [47:0]       diag_round;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= RANGE_LOW_RST;
      cell_scale  <= CELL_SCALE_RST;
      disc_radius <= RADIUS_RST;
      row_cells   <= ROWS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RANGE_LOW:   range_low   <= pwdata;
        REG_CELL_SCALE:  cell_scale  <= pwdata;
        REG_DISC_RADIUS: disc_radius <= pwdata[RADIUS_W-1:0];
        REG_ROW_CELLS:   row_cells   <= pwdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_sel)
      REG_RANGE_LOW:   prdata = range_low;
      REG_CELL_SCALE:  prdata = cell_scale;
      REG_DISC_RADIUS: prdata = DATA_W'(disc_radius);
      REG_ROW_CELLS:   prdata = DATA_W'(row_cells);
      default:         prdata = '0;
    endcase
  end

  // Diagonal offset is the radius times cos45, rounded half up.
  assign diag_prod  = disc_radius * COS45_Q16;
  assign diag_round = {1'b0, diag_prod} + 48'd32768;

  // Derived values follow the registers in the next cycle.
  always_ff @(posedge clk) begin
    diag_offset <= diag_round[46:16];
    if (32'(row_cells) > 32'(MAX_ROW_CELLS)) begin
      grid_cells <= CW'(MAX_ROW_CELLS);
    end else begin
      grid_cells <= CW'(row_cells);
    end
  end

endmodule

// ===== rtl/dgcb_axis.sv =====
module dgcb_axis
  import dgcb_pkg::*;
#(
  parameter int MAX_ROW_CELLS = MAX_ROW_CELLS_DEF,
  parameter int CW            = $clog2(MAX_ROW_CELLS + 1)
) (
  input  logic                                clk,
  input  pipe_en_t                            pipe_en,
  input  logic [POS_W-1:0]                    pos,
  input  logic [POS_W-1:0]                    range_low,
  input  logic [31:0]                         cell_scale,
  input  logic [RADIUS_W-1:0]                 disc_radius,
  input  logic [RADIUS_W-1:0]                 diag_offset,
  input  logic [CW-1:0]                       grid_cells,
  output logic [POS_W-1:0]                    pos_out,
  output logic [NUM_COORDS-1:0][CW-1:0]       coord_cell,
  output logic [NUM_COORDS-1:0]               cell_ok
);

  logic [POS_W-1:0]                 pos1, pos2, pos3, pos4;
  logic [32:0]                      base2;
  logic [NUM_COORDS-1:0][33:0]      dist3;
  logic [NUM_COORDS-1:0][49:0]      pp_hi4;
  logic [NUM_COORDS-1:0][48:0]      pp_lo4;
  logic [NUM_COORDS-1:0][33:0]      dist_next;
  logic [NUM_COORDS-1:0][49:0]      pp_hi_next;
  logic [NUM_COORDS-1:0][48:0]      pp_lo_next;
  logic [NUM_COORDS-1:0][CW-1:0]    cell_next;
  logic [NUM_COORDS-1:0]            cell_ok_next;
  logic [33:0]                      base_ext;
  logic [33:0]                      rad_ext;
  logic [33:0]                      off_ext;

  // Stage 1 captures the request, stage 2 takes the distance from the range edge.
  always_ff @(posedge clk) begin
    if (pipe_en.en1) begin
      pos1 <= pos;
    end
    if (pipe_en.en2) begin
      pos2  <= pos1;
      base2 <= {pos1[POS_W-1], pos1} - {range_low[POS_W-1], range_low};
    end
  end

  // The five probe coordinates on this axis.
  assign base_ext = {base2[32], base2};
  assign rad_ext  = {3'b000, disc_radius};
  assign off_ext  = {3'b000, diag_offset};

  always_comb begin
    dist_next[COORD_CENTER]    = base_ext;
    dist_next[COORD_PLUS_RAD]  = base_ext + rad_ext;
    dist_next[COORD_MINUS_RAD] = base_ext - rad_ext;
    dist_next[COORD_PLUS_OFF]  = base_ext + off_ext;
    dist_next[COORD_MINUS_OFF] = base_ext - off_ext;
  end

  always_ff @(posedge clk) begin
    if (pipe_en.en3) begin
      pos3  <= pos2;
      dist3 <= dist_next;
    end
  end

  // Scale by cells per unit length, split into two partial products.
  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      pp_hi_next[k] = $signed(dist3[k][33:17]) * $signed({1'b0, cell_scale});
      pp_lo_next[k] = dist3[k][16:0] * cell_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en.en4) begin
      pos4   <= pos3;
      pp_hi4 <= pp_hi_next;
      pp_lo4 <= pp_lo_next;
    end
  end

  // Join the partial products and bound the cell against the grid.
  always_comb begin
    logic [66:0] prod;
    logic [34:0] quot;
    for (int k = 0; k < NUM_COORDS; k++) begin
      prod = {pp_hi4[k], 17'b0} + {18'b0, pp_lo4[k]};
      quot = prod[66:32];
      if (prod[66]) begin
        // A point just below the range still falls into cell zero.
        cell_ok_next[k] = (&quot) && (|prod[31:0]) && (grid_cells != '0);
        cell_next[k]    = '0;
      end else begin
        cell_ok_next[k] = quot < 35'(grid_cells);
        cell_next[k]    = quot[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en.en5) begin
      pos_out    <= pos4;
      coord_cell <= cell_next;
      cell_ok    <= cell_ok_next;
    end
  end

endmodule

// ===== rtl/dgcb_emit.sv =====
module dgcb_emit
  import dgcb_pkg::*;
#(
  parameter int MAX_ROW_CELLS = MAX_ROW_CELLS_DEF,
  parameter int CW            = $clog2(MAX_ROW_CELLS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          stage_valid,
  output logic                          buf_free,
  input  logic [NUM_COORDS-1:0][CW-1:0] x_cell,
  input  logic [NUM_COORDS-1:0]         x_ok,
  input  logic [NUM_COORDS-1:0][CW-1:0] y_cell,
  input  logic [NUM_COORDS-1:0]         y_ok,
  input  logic [POS_W-1:0]              pos_x,
  input  logic [POS_W-1:0]              pos_y,
  input  logic [CW-1:0]                 grid_cells,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CELL_W-1:0]             cell_x,
  output logic [CELL_W-1:0]             cell_y,
  output logic [INDEX_W-1:0]            cell_index,
  output logic [POS_W-1:0]              item_x,
  output logic [POS_W-1:0]              item_y,
  output logic [COUNT_W-1:0]            entries_total,
  output logic                          last_cell
);

  localparam int IW = 2 * CW + 1;

  logic [NUM_PROBES-1:0]              keep;
  logic [NUM_PROBES-1:0][CW-1:0]      px_next, py_next;
  logic [NUM_PROBES-1:0][INDEX_W-1:0] idx_next;
  logic [NUM_PROBES-1:0]              pend;
  logic [NUM_PROBES-1:0][CW-1:0]      buf_x, buf_y;
  logic [NUM_PROBES-1:0][INDEX_W-1:0] buf_idx;
  logic [NUM_PROBES-1:0]              pick;
  logic [POS_W-1:0]                   buf_pos_x, buf_pos_y;
  logic [COUNT_W-1:0]                 entry_count;
  logic                               out_fire;
  logic                               load;
  logic [CW-1:0]                      sel_x, sel_y;
  logic [INDEX_W-1:0]                 sel_idx;

  // Resolve each probe to a cell, drop misses and repeats, form the index.
  always_comb begin
    logic [NUM_PROBES-1:0] hit;
    logic                  dup;
    logic [IW-1:0]         full;
    for (int j = 0; j < NUM_PROBES; j++) begin
      px_next[j] = x_cell[probe_x_sel(4'(j))];
      py_next[j] = y_cell[probe_y_sel(4'(j))];
      hit[j]     = x_ok[probe_x_sel(4'(j))] & y_ok[probe_y_sel(4'(j))];
      full       = IW'(py_next[j]) * IW'(grid_cells) + IW'(px_next[j]);
      idx_next[j] = INDEX_W'(full);
    end
    for (int j = 0; j < NUM_PROBES; j++) begin
      dup = 1'b0;
      for (int k = 0; k < j; k++) begin
        dup = dup | (hit[k] & (px_next[k] == px_next[j]) & (py_next[k] == py_next[j]));
      end
      keep[j] = hit[j] & ~dup;
    end
  end

  // The lowest pending probe goes out first.
  assign pick      = pend & (~pend + NUM_PROBES'(1));
  assign out_valid = |pend;
  assign out_fire  = out_valid & out_ready;
  assign last_cell = ~|(pend & ~pick);
  assign buf_free  = ~out_valid | (out_fire & last_cell);
  assign load      = stage_valid & buf_free;

  always_comb begin
    sel_x   = '0;
    sel_y   = '0;
    sel_idx = '0;
    for (int j = 0; j < NUM_PROBES; j++) begin
      if (pick[j]) begin
        sel_x   = sel_x | buf_x[j];
        sel_y   = sel_y | buf_y[j];
        sel_idx = sel_idx | buf_idx[j];
      end
    end
  end

  // Pending mask of cells still to send.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= keep;
    end else if (out_fire) begin
      pend <= pend & ~pick;
    end
  end

  // Cell list of the disc being sent.
  always_ff @(posedge clk) begin
    if (load) begin
      buf_x     <= px_next;
      buf_y     <= py_next;
      buf_idx   <= idx_next;
      buf_pos_x <= pos_x;
      buf_pos_y <= pos_y;
    end
  end

  // Saturating count of sent cell entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (out_fire && entry_count != '1) begin
      entry_count <= entry_count + COUNT_W'(1);
    end
  end

  assign cell_x        = CELL_W'(sel_x);
  assign cell_y        = CELL_W'(sel_y);
  assign cell_index    = sel_idx;
  assign item_x        = buf_pos_x;
  assign item_y        = buf_pos_y;
  assign entries_total = (entry_count == '1) ? entry_count : entry_count + COUNT_W'(1);

endmodule

// ===== rtl/disc_to_grid_cell_binning.sv =====
// Disc to grid cell binning.
//
// Each request on the input channel (in_valid/in_ready, pos_x/pos_y) is a disc
// center. The block probes the center, four axis points at the disc radius and
// four diagonal points, maps each to a grid cell and sends every distinct
// in-grid cell on the output channel (out_valid/out_ready), in probe order,
// with last_cell set on the final one. A disc that touches no cell sends nothing.
// An accepted request passes the five front stages and the emit buffer. Results
// go out one per cycle while out_ready is high; a disc holds the buffer until its
// cells (up to nine) are sent, and a new request is taken every cycle while the
// front stages have room, so the emit buffer sets the sustained rate. When the
// receiver stalls, results hold steady and the front stages fill up before
// in_ready falls. Reset clears all valid state and the entry count and restores
// the register defaults; there is no clearing pass. The user must write registers
// over the APB port only while the block is idle; the block does not enforce it.
module disc_to_grid_cell_binning
  import dgcb_pkg::*;
#(
  parameter int MAX_ROW_CELLS = MAX_ROW_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [POS_W-1:0]   pos_x,
  input  logic [POS_W-1:0]   pos_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CELL_W-1:0]  cell_x,
  output logic [CELL_W-1:0]  cell_y,
  output logic [INDEX_W-1:0] cell_index,
  output logic [POS_W-1:0]   item_x,
  output logic [POS_W-1:0]   item_y,
  output logic [COUNT_W-1:0] entries_total,
  output logic               last_cell
);

  localparam int CW = $clog2(MAX_ROW_CELLS + 1);

  logic [POS_W-1:0]              range_low;
  logic [31:0]                   cell_scale;
  logic [RADIUS_W-1:0]           disc_radius;
  logic [RADIUS_W-1:0]           diag_offset;
  logic [CW-1:0]                 grid_cells;
  pipe_en_t                      pipe_en;
  logic                          v1, v2, v3, v4, v5;
  logic                          buf_free;
  logic [POS_W-1:0]              pos_x5, pos_y5;
  logic [NUM_COORDS-1:0][CW-1:0] x_cell, y_cell;
  logic [NUM_COORDS-1:0]         x_ok, y_ok;

  dgcb_cfg #(
    .MAX_ROW_CELLS(MAX_ROW_CELLS),
    .CW(CW)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .range_low(range_low),
    .cell_scale(cell_scale),
    .disc_radius(disc_radius),
    .diag_offset(diag_offset),
    .grid_cells(grid_cells)
  );

  // A stage loads when it is empty or its item moves on.
  always_comb begin
    pipe_en.en5 = ~v5 | buf_free;
    pipe_en.en4 = ~v4 | pipe_en.en5;
    pipe_en.en3 = ~v3 | pipe_en.en4;
    pipe_en.en2 = ~v2 | pipe_en.en3;
    pipe_en.en1 = ~v1 | pipe_en.en2;
  end

  // No request is taken while reset is held.
  assign in_ready = pipe_en.en1 & ~rst;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (pipe_en.en1) v1 <= in_valid;
      if (pipe_en.en2) v2 <= v1;
      if (pipe_en.en3) v3 <= v2;
      if (pipe_en.en4) v4 <= v3;
      if (pipe_en.en5) v5 <= v4;
    end
  end

  dgcb_axis #(
    .MAX_ROW_CELLS(MAX_ROW_CELLS),
    .CW(CW)
  ) u_axis_x (
    .clk(clk),
    .pipe_en(pipe_en),
    .pos(pos_x),
    .range_low(range_low),
    .cell_scale(cell_scale),
    .disc_radius(disc_radius),
    .diag_offset(diag_offset),
    .grid_cells(grid_cells),
    .pos_out(pos_x5),
    .coord_cell(x_cell),
    .cell_ok(x_ok)
  );

  dgcb_axis #(
    .MAX_ROW_CELLS(MAX_ROW_CELLS),
    .CW(CW)
  ) u_axis_y (
    .clk(clk),
    .pipe_en(pipe_en),
    .pos(pos_y),
    .range_low(range_low),
    .cell_scale(cell_scale),
    .disc_radius(disc_radius),
    .diag_offset(diag_offset),
    .grid_cells(grid_cells),
    .pos_out(pos_y5),
    .coord_cell(y_cell),
    .cell_ok(y_ok)
  );

  dgcb_emit #(
    .MAX_ROW_CELLS(MAX_ROW_CELLS),
    .CW(CW)
  ) u_emit (
    .clk(clk),
    .rst(rst),
    .stage_valid(v5),
    .buf_free(buf_free),
    .x_cell(x_cell),
    .x_ok(x_ok),
    .y_cell(y_cell),
    .y_ok(y_ok),
    .pos_x(pos_x5),
    .pos_y(pos_y5),
    .grid_cells(grid_cells),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .cell_index(cell_index),
    .item_x(item_x),
    .item_y(item_y),
    .entries_total(entries_total),
    .last_cell(last_cell)
  );

endmodule

// ===== bench/disc_to_grid_cell_binning_tb.sv =====
module disc_to_grid_cell_binning_tb;
  import dgcb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 250;
  localparam int REPORT_MAX = 10;
  localparam longint COS45 = 46341;

  typedef enum {ROW_CFG, ROW_DISC, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t kind;
    reg_index_t regsel;
    logic [31:0] value;
    logic [31:0] x;
    logic [31:0] y;
    bit hits;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic [INDEX_W-1:0] idx;
  } plan_row_t;

  typedef struct {
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic [INDEX_W-1:0] idx;
    logic [POS_W-1:0] ix;
    logic [POS_W-1:0] iy;
    logic [COUNT_W-1:0] total;
    logic last;
  } cell_rec_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic out_valid;
  logic out_ready;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic [INDEX_W-1:0] cell_index;
  logic [POS_W-1:0] item_x;
  logic [POS_W-1:0] item_y;
  logic [COUNT_W-1:0] entries_total;
  logic last_cell;

  // Shadow copy of the block's registers and entry counter.
  logic [31:0] low_q;
  logic [31:0] scale_q;
  logic [30:0] radius_q;
  logic [10:0] rows_q;
  logic [COUNT_W-1:0] emitted_count;

  cell_rec_t cells_due[$];
  plan_row_t plan[$];
  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int quiet_cycles;

  disc_to_grid_cell_binning #(
    .MAX_ROW_CELLS(MAX_ROW_CELLS_DEF)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .cell_index(cell_index),
    .item_x(item_x),
    .item_y(item_y),
    .entries_total(entries_total),
    .last_cell(last_cell)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queues one expected cell at the tail of the outstanding list.
  task automatic add_due(input cell_rec_t rec);
    cells_due.insert(cells_due.size(), rec);
  endtask

  // Appends one row to the directed stimulus table.
  task automatic add_row(input plan_row_t row);
    plan.insert(plan.size(), row);
  endtask

  // Maps one axis offset from the low edge to a cell; returns 0 when off the grid.
  function automatic bit axis_bin(input longint d, input int unsigned n,
                                  output int unsigned c);
    longint unsigned m;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned q;
    m = (d < 0) ? -d : d;
    hi = m * scale_q[31:16];
    lo = m * scale_q[15:0];
    q = (hi + (lo >> 16)) >> 16;
    c = q[31:0];
    if (d < 0 && q != 0) return 1'b0;
    if (q >= n) return 1'b0;
    return 1'b1;
  endfunction

  // Works out the distinct cells a disc overlaps and queues them in probe order.
  task automatic bin_disc(input logic [31:0] px, input logic [31:0] py);
    longint cx0;
    longint cy0;
    longint lowv;
    longint r;
    longint off;
    longint ox[9];
    longint oy[9];
    int unsigned n;
    int unsigned a;
    int unsigned b;
    int unsigned hx[9];
    int unsigned hy[9];
    int hits;
    bit dup;
    cell_rec_t rec;
    cx0 = $signed(px);
    cy0 = $signed(py);
    lowv = $signed(low_q);
    r = radius_q;
    off = (r * COS45 + 32768) >>> 16;
    ox = '{0, r, -r, 0, 0, off, -off, off, -off};
    oy = '{0, 0, 0, r, -r, off, off, -off, -off};
    n = (rows_q > MAX_ROW_CELLS_DEF) ? MAX_ROW_CELLS_DEF : rows_q;
    hits = 0;
    for (int i = 0; i < NUM_PROBES; i++) begin
      if (!axis_bin(cx0 + ox[i] - lowv, n, a)) continue;
      if (!axis_bin(cy0 + oy[i] - lowv, n, b)) continue;
      dup = 1'b0;
      for (int k = 0; k < hits; k++) begin
        if (hx[k] == a && hy[k] == b) dup = 1'b1;
      end
      if (!dup) begin
        hx[hits] = a;
        hy[hits] = b;
        hits++;
      end
    end
    for (int k = 0; k < hits; k++) begin
      if (emitted_count != '1) emitted_count++;
      rec.cx = CELL_W'(hx[k]);
      rec.cy = CELL_W'(hy[k]);
      rec.idx = INDEX_W'(hy[k] * n + hx[k]);
      rec.ix = px;
      rec.iy = py;
      rec.total = emitted_count;
      rec.last = (k == hits - 1);
      add_due(rec);
    end
  endtask

  function automatic plan_row_t cfg_row(input reg_index_t regsel, input logic [31:0] value);
    plan_row_t row;
    row = '{kind: ROW_CFG, regsel: REG_RANGE_LOW, default: '0};
    row.regsel = regsel;
    row.value = value;
    return row;
  endfunction

  function automatic plan_row_t disc_row(input logic [31:0] x, input logic [31:0] y);
    plan_row_t row;
    row = '{kind: ROW_DISC, regsel: REG_RANGE_LOW, default: '0};
    row.x = x;
    row.y = y;
    return row;
  endfunction

  // A disc whose single cell (or lack of one) is obvious from the settings.
  function automatic plan_row_t known_row(input logic [31:0] x, input logic [31:0] y,
                                          input bit hits, input int cx, input int cy,
                                          input int idx);
    plan_row_t row;
    row = disc_row(x, y);
    row.kind = ROW_KNOWN;
    row.hits = hits;
    row.cx = CELL_W'(cx);
    row.cy = CELL_W'(cy);
    row.idx = INDEX_W'(idx);
    return row;
  endfunction

  // Writes one register over the configuration port and mirrors it.
  task automatic write_reg(input reg_index_t regsel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({regsel, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (regsel)
      REG_RANGE_LOW: low_q = value;
      REG_CELL_SCALE: scale_q = value;
      REG_DISC_RADIUS: radius_q = value[30:0];
      REG_ROW_CELLS: rows_q = value[10:0];
      default: ;
    endcase
    // The bus idles before the next transfer.
    @(posedge clk);
  endtask

  // Offers one disc, with optional idle cycles first, and records its cells.
  task automatic send_disc(input plan_row_t row);
    cell_rec_t rec;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= row.x;
    pos_y <= row.y;
    do @(posedge clk); while (!in_ready);
    if (row.kind != ROW_KNOWN) begin
      bin_disc(row.x, row.y);
    end else if (row.hits) begin
      if (emitted_count != '1) emitted_count++;
      rec.cx = row.cx;
      rec.cy = row.cy;
      rec.idx = row.idx;
      rec.ix = row.x;
      rec.iy = row.y;
      rec.total = emitted_count;
      rec.last = 1'b1;
      add_due(rec);
    end
  endtask

  // Stops offering and waits until every cell has arrived and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (cells_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin : receiver
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endtask

  // Compare each delivered cell with the oldest one outstanding.
  always @(posedge clk) begin : cell_check
    cell_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (cells_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("%0t: cell (%0d,%0d) delivered with none outstanding",
                   $realtime, cell_x, cell_y);
        end
      end else begin
        want = cells_due.pop_front();
        check_field("cell_x", want.cx, cell_x);
        check_field("cell_y", want.cy, cell_y);
        check_field("cell_index", want.idx, cell_index);
        check_field("item_x", want.ix, item_x);
        check_field("item_y", want.iy, item_y);
        check_field("entries_total", want.total, entries_total);
        check_field("last_cell", want.last, last_cell);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", QUIET_LIMIT);
      $display("** disc_to_grid_cell_binning: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] low;
    int scale;
    int radius;
    int rows;
    int count;
    longint span;
    longint off_x;
    longint off_y;
    int unsigned reach;
    plan_row_t row;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    pos_x = '0;
    pos_y = '0;
    hold_requests = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    low_q = RANGE_LOW_RST;
    scale_q = CELL_SCALE_RST;
    radius_q = RADIUS_RST;
    rows_q = ROWS_RST;
    emitted_count = '0;

    // Directed rows, starting from the reset settings.
    add_row(known_row(32'h0000_0000, 32'h0000_0000, 1, 0, 0, 0));
    // Slightly below the low edge still lands in cell 0.
    add_row(known_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0));
    add_row(known_row(32'hFFFF_0000, 32'h0000_0000, 0, 0, 0, 0));
    add_row(known_row(32'h003F_FFFF, 32'h0005_0000, 1, 63, 5, 383));
    add_row(known_row(32'h0040_0000, 32'h0000_0000, 0, 0, 0, 0));
    add_row(known_row(32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0, 0));
    add_row(known_row(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
    add_row(cfg_row(REG_DISC_RADIUS, 32'h0001_0000));
    add_row(disc_row(32'h000A_0000, 32'h000A_0000));
    add_row(disc_row(32'h0000_0000, 32'h0000_0000));
    add_row(disc_row(32'h003F_0000, 32'h003F_0000));
    // Widest radius; the top bit of the write is dropped.
    add_row(cfg_row(REG_DISC_RADIUS, 32'hFFFF_FFFF));
    add_row(disc_row(32'h0000_0000, 32'h0000_0000));
    add_row(disc_row(32'h7FFF_FFFF, 32'h8000_0000));
    // Grid side above the limit is clamped to the limit.
    add_row(cfg_row(REG_DISC_RADIUS, 32'h0000_0000));
    add_row(cfg_row(REG_ROW_CELLS, 32'd2047));
    add_row(known_row(32'h03FF_0000, 32'h03FF_0000, 1, 1023, 1023, 1048575));
    add_row(known_row(32'h0400_0000, 32'h0000_0000, 0, 0, 0, 0));
    add_row(known_row(32'h0005_0000, 32'h03FF_0000, 1, 5, 1023, 1047557));
    // Empty grid: nothing can be emitted.
    add_row(cfg_row(REG_ROW_CELLS, 32'd0));
    add_row(known_row(32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0));
    // One-cell grid at the bottom of the range with the largest scale.
    add_row(cfg_row(REG_ROW_CELLS, 32'd1));
    add_row(cfg_row(REG_CELL_SCALE, 32'hFFFF_FFFF));
    add_row(cfg_row(REG_RANGE_LOW, 32'h8000_0000));
    add_row(known_row(32'h8000_0000, 32'h8000_0000, 1, 0, 0, 0));
    add_row(known_row(32'h8000_0001, 32'h8000_0000, 1, 0, 0, 0));
    add_row(known_row(32'h8000_0002, 32'h8000_0000, 0, 0, 0, 0));
    add_row(known_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
    // Zero scale folds every probe into cell 0, even far below the low edge.
    add_row(cfg_row(REG_RANGE_LOW, 32'h7FFF_FFFF));
    add_row(cfg_row(REG_CELL_SCALE, 32'h0000_0000));
    add_row(cfg_row(REG_ROW_CELLS, 32'd1024));
    add_row(cfg_row(REG_DISC_RADIUS, 32'h7FFF_FFFF));
    add_row(known_row(32'h8000_0000, 32'hFFFF_FFFF, 1, 0, 0, 0));
    add_row(disc_row(32'h7FFF_FFFF, 32'h7FFF_FFFF));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].regsel, plan[i].value);
      end else begin
        send_disc(plan[i]);
      end
    end

    // Random phases, each with its own settings and idling pattern.
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      low = $urandom;
      scale = (1 << $urandom_range(13, 19));
      if ($urandom_range(0, 1)) scale += $urandom_range(0, scale / 2);
      radius = $urandom_range(0, 3 << 16);
      rows = $urandom_range(1, 40);
      write_reg(REG_ROW_CELLS, rows);
      write_reg(REG_CELL_SCALE, scale);
      write_reg(REG_DISC_RADIUS, radius);
      write_reg(REG_RANGE_LOW, low);
      case (phase)
        1: begin
          send_idle_pct = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 78;
        end
        3: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      count = (phase == 4) ? 40 : 45;
      span = (longint'(rows) << 32) / scale;
      reach = 32'(span + 2 * radius + (2 << 16));
      for (int i = 0; i < count; i++) begin
        // Long receiver hold-off while requests keep coming.
        if (phase == 4 && i == 10) hold_requests++;
        // Sender waits for every outstanding cell before going on.
        if (phase == 4 && i == 25) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (cells_due.size() != 0);
        end
        if ($urandom_range(0, 99) < 85) begin
          off_x = longint'($urandom_range(0, reach)) - radius - (1 << 16);
          off_y = longint'($urandom_range(0, reach)) - radius - (1 << 16);
          row = disc_row(low + off_x[31:0], low + off_y[31:0]);
        end else begin
          row = disc_row($urandom, $urandom);
        end
        send_disc(row);
      end
    end

    settle();
    if (mismatch_count == 0 && cells_due.size() == 0) begin
      $display("** disc_to_grid_cell_binning: PASSED **");
    end else begin
      $display("** disc_to_grid_cell_binning: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dgcb_pkg.sv
rtl/dgcb_cfg.sv
rtl/dgcb_axis.sv
rtl/dgcb_emit.sv
rtl/disc_to_grid_cell_binning.sv
bench/disc_to_grid_cell_binning_tb.sv
